// File: rtl/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging registration table package
// Shared item types, command and result codes, and the table entry layout.
// ----------------------------------------------------------------------------
package art_pkg;

	localparam int unsigned AGE_W = 14;
	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 14'd10000;

	localparam logic [2:0] CMD_LIST     = 3'd0;
	localparam logic [2:0] CMD_REGISTER = 3'd1;
	localparam logic [2:0] CMD_REMOVE   = 3'd2;
	localparam logic [2:0] CMD_ECHO     = 3'd3;
	localparam logic [2:0] CMD_TICK     = 3'd4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ENTRY  = 2'd1;
	localparam logic [1:0] KIND_ECHO   = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] client_address;
		logic [15:0] client_port;
		logic [31:0] entry_info;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  active_count;
		logic [31:0] out_address;
		logic [15:0] out_port;
		logic [31:0] out_info;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0]      address;
		logic [15:0]      port;
		logic [31:0]      payload;
		logic [AGE_W-1:0] age;
	} entry_t;

endpackage

// File: rtl/aging_registration_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging registration table
// Table of registrations keyed by address and port, with per-entry aging.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Register, remove and tick items walk
// every slot but reserved slot 0 through the single read port of the entry
// RAM; a register item that finds the table full then returns a full result,
// which waits if the result side stalls. A list item returns a header, then
// walks the slots up to the last active entry and returns one result per
// active entry; each result waits if the result side stalls. An echo
// item returns one result, which waits if the result side stalls. Slot 0 is
// reserved, so at most TABLE_SLOTS - 1 entries are active. Valid bits live in
// flip-flops and reset clears them at once, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module aging_registration_table_top
	import art_pkg::*;
#(
	parameter int unsigned TABLE_SLOTS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [AGE_W-1:0] cfg_data
);

	localparam int unsigned IW = $clog2(TABLE_SLOTS);
	localparam int unsigned EW = $bits(entry_t);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_LHEAD  = 3'd3;
	localparam logic [2:0] ST_LSCAN  = 3'd4;
	localparam logic [2:0] ST_LWAIT  = 3'd5;
	localparam logic [2:0] ST_ECHO   = 3'd6;
	localparam logic [2:0] ST_FULL   = 3'd7;

	localparam logic [IW:0] PTR_END = (IW+1)'(TABLE_SLOTS);
	localparam logic [IW:0] PTR_FIRST = (IW+1)'(1);

	logic [2:0]             state_q;
	logic [2:0]             cmd_q;
	logic [31:0]            addr_q;
	logic [15:0]            port_q;
	logic [31:0]            info_q;
	logic [AGE_W-1:0]       age_limit_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [IW-1:0]          count_q;
	logic [IW-1:0]          seen_q;
	logic [IW:0]            ptr_q;
	logic                   vld_s1;
	logic [IW-1:0]          idx_s1;
	logic                   found_q;
	logic [IW-1:0]          match_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic                   ram_wr_en;
	logic [IW-1:0]          ram_wr_addr;
	entry_t                 ram_wr_data;
	logic                   ram_rd_en;
	logic [EW-1:0]          ram_rd_data;
	entry_t                 rd_entry;

	logic [IW-1:0]          ptr_idx;
	logic                   ptr_done;
	logic                   out_free;
	logic                   accept;
	logic [AGE_W:0]         age_inc;
	logic                   expire;
	logic                   key_hit;
	logic                   tick_wb;
	logic [IW-1:0]          seen_next;
	logic                   load_out;
	out_item_t              out_next;

	art_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ptr_idx),
		.rd_data (ram_rd_data)
	);

	assign rd_entry  = entry_t'(ram_rd_data);
	assign ptr_idx   = ptr_q[IW-1:0];
	assign ptr_done  = (ptr_q == PTR_END);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign age_inc   = {1'b0, rd_entry.age} + (AGE_W+1)'(1);
	assign expire    = (age_inc > {1'b0, age_limit_q});
	assign key_hit   = vld_s1 && valid_q[idx_s1] && (rd_entry.address == addr_q) &&
		(rd_entry.port == port_q);
	assign tick_wb   = (state_q == ST_SCAN) && (cmd_q == CMD_TICK) && vld_s1 &&
		valid_q[idx_s1];
	assign seen_next = seen_q + IW'(1);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_s1;
		ram_wr_data = rd_entry;
		load_out    = 1'b0;
		out_next    = '0;
		case (state_q)
			ST_SCAN: begin
				ram_rd_en = !ptr_done;
				if (tick_wb) begin
					ram_wr_en = 1'b1;
					ram_wr_data.age = expire ? '0 : age_inc[AGE_W-1:0];
				end
			end
			ST_DECIDE: begin
				if ((cmd_q == CMD_REGISTER) && (found_q || free_found_q)) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = found_q ? match_q : free_q;
					ram_wr_data = '{address: addr_q, port: port_q, payload: info_q,
						age: '0};
				end
			end
			ST_LHEAD: begin
				load_out              = out_free;
				out_next.kind         = KIND_HEADER;
				out_next.active_count = 5'(count_q);
				out_next.last         = (count_q == '0);
			end
			ST_LSCAN: begin
				ram_rd_en = !ptr_done && valid_q[ptr_idx];
			end
			ST_LWAIT: begin
				load_out             = out_free;
				out_next.kind        = KIND_ENTRY;
				out_next.out_address = rd_entry.address;
				out_next.out_port    = rd_entry.port;
				out_next.out_info    = rd_entry.payload;
				out_next.last        = (seen_next == count_q);
			end
			ST_ECHO: begin
				load_out             = out_free;
				out_next.kind        = KIND_ECHO;
				out_next.out_address = addr_q;
				out_next.last        = 1'b1;
			end
			ST_FULL: begin
				load_out      = out_free;
				out_next.kind = KIND_FULL;
				out_next.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= CMD_LIST;
			age_limit_q  <= AGE_LIMIT_RESET;
			valid_q      <= '0;
			count_q      <= '0;
			seen_q       <= '0;
			ptr_q        <= PTR_FIRST;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				age_limit_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					vld_s1       <= 1'b0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					seen_q       <= '0;
					ptr_q        <= PTR_FIRST;
					if (accept) begin
						cmd_q <= in_item.cmd;
						case (in_item.cmd)
							CMD_LIST:                          state_q <= ST_LHEAD;
							CMD_REGISTER, CMD_REMOVE, CMD_TICK: state_q <= ST_SCAN;
							CMD_ECHO:                          state_q <= ST_ECHO;
							default:                           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= !ptr_done;
					if (!ptr_done) begin
						ptr_q <= ptr_q + PTR_FIRST;
					end
					if (key_hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (tick_wb && expire) begin
						valid_q[idx_s1] <= 1'b0;
						count_q         <= count_q - IW'(1);
					end
					if (ptr_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					if (cmd_q == CMD_REGISTER) begin
						if (!found_q && free_found_q) begin
							valid_q[free_q] <= 1'b1;
							count_q         <= count_q + IW'(1);
						end else if (!found_q) begin
							state_q <= ST_FULL;
						end
					end else if ((cmd_q == CMD_REMOVE) && found_q) begin
						valid_q[match_q] <= 1'b0;
						count_q          <= count_q - IW'(1);
					end
				end
				ST_LHEAD: begin
					if (out_free) begin
						state_q <= (count_q == '0) ? ST_IDLE : ST_LSCAN;
					end
				end
				ST_LSCAN: begin
					if (ptr_done) begin
						state_q <= ST_IDLE;
					end else if (valid_q[ptr_idx]) begin
						state_q <= ST_LWAIT;
					end else begin
						ptr_q <= ptr_q + PTR_FIRST;
					end
				end
				ST_LWAIT: begin
					if (out_free) begin
						seen_q  <= seen_next;
						ptr_q   <= ptr_q + PTR_FIRST;
						state_q <= (seen_next == count_q) ? ST_IDLE : ST_LSCAN;
					end
				end
				ST_ECHO, ST_FULL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= in_item.client_address;
			port_q <= in_item.client_port;
			info_q <= in_item.entry_info;
		end
		idx_s1 <= ptr_idx;
		if ((state_q == ST_SCAN) && key_hit && !found_q) begin
			match_q <= idx_s1;
		end
		if ((state_q == ST_SCAN) && vld_s1 && !valid_q[idx_s1] && !free_found_q) begin
			free_q <= idx_s1;
		end
		if (load_out) begin
			out_q <= out_next;
		end
	end

	a_slot0_unused: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[0])
		else $error("reserved slot 0 became active");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (IW+1)'(TABLE_SLOTS - 1))
		else $error("active count exceeds usable slots");

	a_list_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LSCAN) |-> !ptr_done)
		else $error("list walk ran past the table before the last entry");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> (((state_q == ST_SCAN) && (cmd_q == CMD_TICK)) ||
		((state_q == ST_DECIDE) && (cmd_q == CMD_REGISTER))))
		else $error("entry RAM written outside a tick or register item");

	a_last_ends_list: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_next.last && (state_q == ST_LWAIT)) |=> (state_q == ST_IDLE))
		else $error("list did not finish after its last entry");

endmodule

// File: rtl/art_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
